[rtl/mcr_pkg.sv]
// Shared types and constants for the midpoint circle rasterizer.
`timescale 1ns / 1ps

package mcr_pkg;

    // Request kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // Eight symmetric pixels per set
    localparam int unsigned PIX_IDX_BITS = 3;
    localparam logic [PIX_IDX_BITS-1:0] PIX_IDX_LAST = 3'd7;

    // Set queue between front and back
    localparam int unsigned Q_DEPTH    = 2;
    localparam int unsigned Q_PTR_BITS = 1;
    localparam int unsigned Q_CNT_BITS = 2;

    typedef struct packed {
        logic full;
        logic not_empty;
    } mcr_q_status_t;

endpackage

[rtl/mcr_front.sv]
// Front end: accepts requests, advances the midpoint state, queues pixel sets.
`timescale 1ns / 1ps

module mcr_front #(
    parameter int unsigned COORD_BITS  = 12,
    parameter int unsigned RADIUS_BITS = 10
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic                                      kind,
    input  logic signed [COORD_BITS-1:0]              center_x,
    input  logic signed [COORD_BITS-1:0]              center_y,
    input  logic        [RADIUS_BITS-1:0]             radius,
    input  mcr_pkg::mcr_q_status_t                    q_status,
    output logic                                      push,
    output logic [2*COORD_BITS+2*RADIUS_BITS:0]       push_data
);
    import mcr_pkg::*;

    localparam int unsigned DEC_BITS = RADIUS_BITS + 3;

    logic signed [COORD_BITS-1:0]  held_cx_reg, held_cx_next;
    logic signed [COORD_BITS-1:0]  held_cy_reg, held_cy_next;
    logic        [RADIUS_BITS-1:0] x_reg, x_next;
    logic        [RADIUS_BITS-1:0] y_reg, y_next;
    logic        [DEC_BITS-1:0]    dec_reg, dec_next;
    logic                          active_reg, active_next;

    logic                   accept;
    logic                   is_start;
    logic                   can_step;
    logic                   moving;
    logic [RADIUS_BITS-1:0] x_inc;
    logic [RADIUS_BITS-1:0] y_dec;
    logic [RADIUS_BITS-1:0] y_new;
    logic [DEC_BITS-1:0]    dec_step;
    logic [DEC_BITS-1:0]    dec_start;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign is_start = (kind == KIND_START);
    assign can_step = active_reg && (x_reg < y_reg);

    assign x_inc  = x_reg + {{(RADIUS_BITS-1){1'b0}}, 1'b1};
    assign y_dec  = y_reg - {{(RADIUS_BITS-1){1'b0}}, 1'b1};
    // decision >= 0 means the midpoint is outside: step diagonally
    assign moving = !dec_reg[DEC_BITS-1];
    assign y_new  = moving ? y_dec : y_reg;

    // d += 2x + 1, less 2y on a diagonal move (x, y already updated)
    assign dec_step = dec_reg + {2'b00, x_inc, 1'b1}
                    - (moving ? {2'b00, y_new, 1'b0} : {DEC_BITS{1'b0}});
    assign dec_start = {{(DEC_BITS-1){1'b0}}, 1'b1} - {3'b000, radius};

    always_comb
    begin
        held_cx_next = held_cx_reg;
        held_cy_next = held_cy_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        dec_next     = dec_reg;
        active_next  = active_reg;
        push         = 1'b0;
        push_data    = {held_cx_reg, held_cy_reg, x_inc, y_new, !(x_inc < y_new)};
        if (accept)
        begin
            if (is_start)
            begin
                held_cx_next = center_x;
                held_cy_next = center_y;
                x_next       = {RADIUS_BITS{1'b0}};
                y_next       = radius;
                dec_next     = dec_start;
                active_next  = (radius != {RADIUS_BITS{1'b0}});
                push         = 1'b1;
                push_data    = {center_x, center_y, {RADIUS_BITS{1'b0}}, radius,
                                (radius == {RADIUS_BITS{1'b0}})};
            end
            else if (can_step)
            begin
                x_next      = x_inc;
                y_next      = y_new;
                dec_next    = dec_step;
                active_next = (x_inc < y_new);
                push        = 1'b1;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cx_reg <= '0;
            held_cy_reg <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            dec_reg     <= '0;
            active_reg  <= 1'b0;
        end
        else
        begin
            held_cx_reg <= held_cx_next;
            held_cy_reg <= held_cy_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            dec_reg     <= dec_next;
            active_reg  <= active_next;
        end
    end

    // An active circle always has at least one set left to produce
    a_active_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (x_reg < y_reg))
        else $error("active circle with x not below y");

    // A start always leaves x at zero and y at the requested radius
    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_start) |=> (x_reg == '0) && (y_reg == $past(radius)))
        else $error("start did not load offsets");

endmodule

[rtl/mcr_queue.sv]
// Small FIFO of pending pixel sets between front and back.
`timescale 1ns / 1ps

module mcr_queue #(
    parameter int unsigned WIDTH = 45
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       head_data,
    output mcr_pkg::mcr_q_status_t q_status
);
    import mcr_pkg::*;

    logic [WIDTH-1:0]      entry_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0] count_reg, count_next;

    assign q_status.full      = (count_reg == Q_CNT_BITS'(Q_DEPTH));
    assign q_status.not_empty = (count_reg != '0);
    assign head_data          = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!q_status.full || pop))
        else $error("set queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.not_empty)
        else $error("set queue underflow");

endmodule

[rtl/mcr_back.sv]
// Back end: walks each queued set through its eight pixels into the output register.
`timescale 1ns / 1ps

module mcr_back #(
    parameter int unsigned COORD_BITS  = 12,
    parameter int unsigned RADIUS_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mcr_pkg::mcr_q_status_t              q_status,
    input  logic [2*COORD_BITS+2*RADIUS_BITS:0] head_data,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_BITS:0]          pixel_x,
    output logic signed [COORD_BITS:0]          pixel_y,
    output logic                                last_of_set,
    output logic                                circle_done
);
    import mcr_pkg::*;

    localparam int unsigned SUM_BITS = COORD_BITS + RADIUS_BITS + 1;

    logic [PIX_IDX_BITS-1:0] idx_reg, idx_next;
    logic                    out_valid_reg, out_valid_next;
    logic [COORD_BITS:0]     pixel_x_reg;
    logic [COORD_BITS:0]     pixel_y_reg;
    logic                    last_reg;
    logic                    done_reg;

    logic [COORD_BITS-1:0]  cx, cy;
    logic [RADIUS_BITS-1:0] off_x, off_y;
    logic                   set_done;
    logic [RADIUS_BITS-1:0] a_off, b_off;
    logic [SUM_BITS-1:0]    cx_e, cy_e, a_e, b_e, px_s, py_s;
    logic                   load;
    logic                   is_last;

    assign {cx, cy, off_x, off_y, set_done} = head_data;

    // idx[2] swaps the offsets, idx[0] negates the x term, !idx[1] the y term
    assign a_off = idx_reg[2] ? off_y : off_x;
    assign b_off = idx_reg[2] ? off_x : off_y;
    assign cx_e  = {{(SUM_BITS-COORD_BITS){cx[COORD_BITS-1]}}, cx};
    assign cy_e  = {{(SUM_BITS-COORD_BITS){cy[COORD_BITS-1]}}, cy};
    assign a_e   = {{(SUM_BITS-RADIUS_BITS){1'b0}}, a_off};
    assign b_e   = {{(SUM_BITS-RADIUS_BITS){1'b0}}, b_off};
    assign px_s  = idx_reg[0] ? cx_e - a_e : cx_e + a_e;
    assign py_s  = idx_reg[1] ? cy_e + b_e : cy_e - b_e;

    assign is_last = (idx_reg == PIX_IDX_LAST);
    assign load    = q_status.not_empty && (!out_valid_reg || out_ready);
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next       = load ? idx_reg + 1'b1 : idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_x_reg <= px_s[COORD_BITS:0];
            pixel_y_reg <= py_s[COORD_BITS:0];
            last_reg    <= is_last;
            done_reg    <= set_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign last_of_set = last_reg;
    assign circle_done = done_reg;

    // Retiring a set leaves the walker at the first pixel of the next one
    a_pop_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == '0) && out_valid_reg && last_reg)
        else $error("set retired without ending on last pixel");

endmodule

[rtl/midpoint_circle_rasterizer_unit.sv]
// Top level of the midpoint circle rasterizer.
`timescale 1ns / 1ps

// Midpoint circle rasterizer. A start request (kind 0) loads center and radius and
// produces the eight symmetric pixels of the point x = 0, y = radius; each step
// request (kind 1) advances the midpoint decision one column and produces the next
// eight pixels, until x is no longer below y. Steps with no circle in progress are
// taken and produce nothing. Every pixel set comes out one pixel per cycle through
// the single output port while out_ready is held high. The front end updates the
// circle state and places each set in a two-entry queue; the back end walks the
// queue head through its eight pixels into an output register. Requests keep
// flowing while the queue has room, and a step that makes nothing is still taken
// at the input. A taken request's set is written into the queue, and once it is the
// queue head and the output side is free, its first pixel is loaded into the output
// register. last_of_set marks the eighth pixel of each set, circle_done marks every
// pixel of the circle's final set (including radius zero). Pixel coordinates wrap
// to COORD_BITS+1 bits.

module midpoint_circle_rasterizer_unit #(
    parameter int unsigned COORD_BITS  = 12,
    parameter int unsigned RADIUS_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic signed [COORD_BITS-1:0]  center_x,
    input  logic signed [COORD_BITS-1:0]  center_y,
    input  logic        [RADIUS_BITS-1:0] radius,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_BITS:0]    pixel_x,
    output logic signed [COORD_BITS:0]    pixel_y,
    output logic                          last_of_set,
    output logic                          circle_done
);
    import mcr_pkg::*;

    // Queued set: center x, center y, x offset, y offset, final-set flag
    localparam int unsigned SET_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

    mcr_q_status_t       q_status;
    logic                push;
    logic                pop;
    logic [SET_BITS-1:0] push_data;
    logic [SET_BITS-1:0] head_data;

    mcr_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    mcr_queue #(
        .WIDTH (SET_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .q_status  (q_status)
    );

    mcr_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .head_data   (head_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .last_of_set (last_of_set),
        .circle_done (circle_done)
    );

endmodule
